// File: rtl/fsa_pkg.sv
// shared types and constants of the free list slot allocator
`default_nettype none

package fsa_pkg;

	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned STATUS_W = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_we;
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/fsa_ctrl.sv
// control state machine of the free list slot allocator
`default_nettype none

module fsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire fsa_pkg::dp_status_t st,
	output fsa_pkg::ctrl_cmd_t      ctl
);

	fsa_pkg::state_t state_q;
	fsa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		ctl.clr_we = 1'b0;
		ctl.accept = 1'b0;
		ctl.commit = 1'b0;
		unique case (state_q)
			fsa_pkg::ST_CLEAR: begin
				ctl.clr_we = 1'b1;
				if (st.clr_last) begin
					state_d = fsa_pkg::ST_IDLE;
				end
			end
			fsa_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
				if (in_valid) begin
					state_d = fsa_pkg::ST_COMMIT;
				end
			end
			fsa_pkg::ST_COMMIT: begin
				if (st.out_free) begin
					ctl.commit = 1'b1;
					state_d    = fsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsa_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fsa_dpath.sv
// head register, link memory, request and result registers
`default_nettype none

module fsa_dpath #(
	parameter int unsigned POOL_SLOTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fsa_pkg::ctrl_cmd_t            ctl,
	output fsa_pkg::dp_status_t                st,
	input  wire logic                          cmd,
	input  wire logic [fsa_pkg::SLOT_W-1:0]    slot_index,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [fsa_pkg::STATUS_W-1:0]       status,
	output logic [fsa_pkg::SLOT_W-1:0]         granted_slot
);

	localparam int unsigned AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int unsigned HW = $clog2(POOL_SLOTS + 1);
	localparam int unsigned CW = ((HW > fsa_pkg::SLOT_W) ? HW : fsa_pkg::SLOT_W) + 1;
	localparam logic [HW-1:0] EMPTY_HEAD = HW'(POOL_SLOTS);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(POOL_SLOTS - 1);

	logic [HW-1:0] mem [POOL_SLOTS];

	logic [HW-1:0]                 head_q;
	logic [AW-1:0]                 clr_q;
	logic [HW-1:0]                 rd_q;
	logic                          req_cmd_q;
	logic [fsa_pkg::SLOT_W-1:0]    req_slot_q;
	logic                          out_valid_q;
	logic [fsa_pkg::STATUS_W-1:0]  status_q;
	logic [fsa_pkg::SLOT_W-1:0]    granted_q;

	logic          empty;
	logic          in_range;
	logic          do_free;
	logic          do_pop;
	logic [CW-1:0] slot_ext;
	logic [CW-1:0] head_ext;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [HW-1:0] wr_data;

	assign empty    = (head_q >= EMPTY_HEAD);
	assign slot_ext = CW'(req_slot_q);
	assign head_ext = CW'(head_q);
	assign in_range = (slot_ext < CW'(POOL_SLOTS));
	assign do_free  = ctl.commit && (req_cmd_q == fsa_pkg::CMD_FREE) && in_range;
	assign do_pop   = ctl.commit && (req_cmd_q == fsa_pkg::CMD_ALLOC) && !empty;

	assign st.clr_last = (clr_q == LAST_ADDR);
	assign st.out_free = !out_valid_q || !out_stall;

	// single write port: init sweep or push of a freed slot
	assign we      = ctl.clr_we || do_free;
	assign wr_addr = ctl.clr_we ? clr_q : slot_ext[AW-1:0];
	assign wr_data = ctl.clr_we ? (HW'(clr_q) + HW'(1)) : head_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// link of the current head is fetched as the item comes in
	always_ff @(posedge clk) begin
		if (ctl.accept && !empty) begin
			rd_q <= mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			req_cmd_q  <= cmd;
			req_slot_q <= slot_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			clr_q  <= '0;
		end else begin
			if (ctl.clr_we) begin
				clr_q <= clr_q + AW'(1);
			end
			if (do_free) begin
				head_q <= slot_ext[HW-1:0];
			end else if (do_pop) begin
				head_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			granted_q <= '0;
			if (req_cmd_q == fsa_pkg::CMD_FREE) begin
				status_q <= in_range ? fsa_pkg::STATUS_OK : fsa_pkg::STATUS_RANGE;
			end else if (empty) begin
				status_q <= fsa_pkg::STATUS_EMPTY;
			end else begin
				status_q  <= fsa_pkg::STATUS_OK;
				granted_q <= head_ext[fsa_pkg::SLOT_W-1:0];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;

endmodule

`default_nettype wire

// File: rtl/free_list_slot_allocator_core.sv
// top level of the lifo free list slot allocator
// flow: a request is registered as it is taken and its result registered at commit, which
//   waits while a stalled result is held; a new request is taken only after the held one
//   commits, set by the registered read of the link memory ahead of each head update
// reset: head goes to slot 0, then an init sweep writes link i = i+1 over all
//   POOL_SLOTS entries, one a cycle, with in_stall held high
`default_nettype none

module free_list_slot_allocator_core #(
	parameter int unsigned POOL_SLOTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic [fsa_pkg::SLOT_W-1:0]    slot_index,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [fsa_pkg::STATUS_W-1:0]       status,
	output logic [fsa_pkg::SLOT_W-1:0]         granted_slot
);

	// commands: init sweep write, item accept, commit of the held item
	fsa_pkg::ctrl_cmd_t  ctl;
	// status: last sweep entry, result register able to take a new item
	fsa_pkg::dp_status_t st;

	// sequencer: init sweep, idle (takes an item), commit (waits for the output side)
	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.ctl      (ctl)
	);

	// head pointer, link memory, held item and the result register
	// allocate pops head and loads head from the fetched link; free pushes
	// the slot with the old head as its link; out of range frees change nothing
	fsa_dpath #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.cmd          (cmd),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_slot (granted_slot)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench of the lifo free list slot allocator core
`timescale 1ns / 100ps

module tb;

	localparam int unsigned POOL_SLOTS = 1024;
	localparam int unsigned SLOT_W     = fsa_pkg::SLOT_W;
	localparam int unsigned STATUS_W   = fsa_pkg::STATUS_W;

	// one result as the block reports it
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   granted;
	} grant_t;

	// one row of the directed table; fixed rows carry the result read off by hand
	typedef struct packed {
		logic         cmd;
		logic [SLOT_W-1:0] slot;
		logic         fixed;
		grant_t       want;
	} dir_row_t;

	// after reset the list runs 0, 1, 2, ... so the first pops are plain to read;
	// an out-of-range free cannot be driven at this pool size, as the index field
	// never reaches POOL_SLOTS
	localparam int DIR_N = 19;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'd1023, 1'b1, '{fsa_pkg::STATUS_OK, 10'd1}},
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd2}},
		'{fsa_pkg::CMD_FREE,  10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'd1023, 1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'd2,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'd1,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd1}},
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd2}},
		'{fsa_pkg::CMD_ALLOC, 10'd0,    1'b1, '{fsa_pkg::STATUS_OK, 10'd3}},
		'{fsa_pkg::CMD_ALLOC, 10'h155,  1'b0, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'h2aa,  1'b0, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'd3,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'h005,  1'b0, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'h3ff,  1'b0, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_FREE,  10'd1,    1'b1, '{fsa_pkg::STATUS_OK, 10'd0}},
		'{fsa_pkg::CMD_ALLOC, 10'h000,  1'b0, '{fsa_pkg::STATUS_OK, 10'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [SLOT_W-1:0] slot_index;
	logic out_valid;
	logic out_stall;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] granted_slot;

	// shadow of the free list: head and one link per slot, POOL_SLOTS means empty
	logic [SLOT_W:0] pool_head;
	logic [SLOT_W:0] pool_link [POOL_SLOTS];

	grant_t grant_q [$];       // results still owed by the block, oldest first
	int unsigned loaned_q [$]; // slots handed out and not yet given back
	int empties_seen;
	int n_sent;
	int mism_cnt;
	bit calm;                  // stretch with no idling on either side
	bit tail_run;              // last part of the run, no idling at all
	bit long_hold_done;

	always #5 clk = ~clk;

	free_list_slot_allocator_core #(
		.POOL_SLOTS(POOL_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.granted_slot(granted_slot)
	);

	// pop or push on the shadow list, returns what the block must report
	function automatic grant_t predict_grant(logic c, logic [SLOT_W-1:0] s);
		grant_t r;
		int k;
		r.status  = fsa_pkg::STATUS_OK;
		r.granted = '0;
		if (c == fsa_pkg::CMD_FREE) begin
			if (int'(s) >= POOL_SLOTS) begin
				r.status = fsa_pkg::STATUS_RANGE;
			end else begin
				pool_link[s] = pool_head;
				pool_head = {1'b0, s};
				// the slot is back on the list, stop offering it for a free
				for (k = 0; k < loaned_q.size(); k++) begin
					if (loaned_q[k] == s) begin
						loaned_q.delete(k);
						break;
					end
				end
			end
		end else if (pool_head >= POOL_SLOTS) begin
			// pool exhausted, nothing moves
			r.status = fsa_pkg::STATUS_EMPTY;
			empties_seen++;
		end else begin
			r.granted = pool_head[SLOT_W-1:0];
			loaned_q.push_back(32'(pool_head));
			pool_head = pool_link[pool_head[SLOT_W-1:0]];
		end
		return r;
	endfunction

	// offer one item, hold it until taken, then log what it must produce
	task automatic send_req(input logic c, input logic [SLOT_W-1:0] s,
			input logic fixed, input grant_t want);
		grant_t pred;
		calm = ((n_sent / 64) % 3) == 2;
		tail_run = n_sent >= 1100;
		// random gap ahead of the item
		if (!calm && !tail_run && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		slot_index <= s;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pred = predict_grant(c, s);
		grant_q.push_back(fixed ? want : pred);
		n_sent++;
		@(negedge clk);
	endtask

	// sender stops until every owed result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (grant_q.size() != 0);
	endtask

	// result checker, outputs sampled at the rising edge
	always @(posedge clk) begin : chk_blk
		grant_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (grant_q.size() == 0) begin
				$error("result with none owed: status %0d granted_slot %0d",
					status, granted_slot);
				mism_cnt++;
			end else begin
				want = grant_q.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mism_cnt++;
				end
				if (granted_slot !== want.granted) begin
					$error("granted_slot: expected %0d, got %0d",
						want.granted, granted_slot);
					mism_cnt++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin : rx_blk
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && n_sent >= 300) begin
				// long hold-off so the pipe fills and the request side backs up
				out_stall <= 1'b1;
				repeat (200) @(negedge clk);
				long_hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && !tail_run && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 12) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus
	initial begin : stim_blk
		int i;
		int r;
		bit do_alloc;
		grant_t none;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = fsa_pkg::CMD_ALLOC;
		slot_index = '0;
		for (i = 0; i < POOL_SLOTS; i++)
			pool_link[i] = (SLOT_W + 1)'(i + 1);
		pool_head = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		// first item simply waits out the init sweep through in_stall

		// directed table
		for (i = 0; i < DIR_N; i++)
			send_req(DIR_ROWS[i].cmd, DIR_ROWS[i].slot, DIR_ROWS[i].fixed,
				DIR_ROWS[i].want);
		drain_results();

		// random part: drain the pool to empty first, then churn around empty,
		// and once eight empty results have been seen, throw in stray frees that can double free
		r = 0;
		while (r < 1250 || empties_seen < 8) begin
			if (r == 600)
				drain_results();
			if (empties_seen >= 8 && $urandom_range(0, 4) == 0) begin
				send_req(fsa_pkg::CMD_FREE, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)),
					1'b0, none);
			end else begin
				if (loaned_q.size() == 0)
					do_alloc = 1'b1;
				else if (empties_seen == 0)
					do_alloc = $urandom_range(0, 19) != 0;
				else
					do_alloc = ($urandom_range(0, 1) != 0);
				if (do_alloc)
					send_req(fsa_pkg::CMD_ALLOC, SLOT_W'($urandom_range(0, 1023)),
						1'b0, none);
				else
					send_req(fsa_pkg::CMD_FREE,
						SLOT_W'(loaned_q[$urandom_range(0, loaned_q.size() - 1)]),
						1'b0, none);
			end
			r++;
		end
		in_valid <= 1'b0;

		// let the last results out, then a short quiet tail
		do @(negedge clk); while (grant_q.size() != 0);
		repeat (8) @(negedge clk);
		if (mism_cnt == 0 && grant_q.size() == 0)
			$display("free_list_slot_allocator_core test passed");
		else
			$display("free_list_slot_allocator_core test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("free_list_slot_allocator_core test failed");
		$finish;
	end

endmodule
